### src/plst_pkg.sv
// Package for the piecewise linear stop table.
// Holds sizes, command codes and sequencer states; no dependencies.
`default_nettype none
package plst_pkg;
    localparam int MaxStops = 32;
    localparam int IdxW = $clog2(MaxStops);
    localparam int CntW = $clog2(MaxStops + 1);
    localparam int PosW = 17;
    localparam int LvlW = 16;
    localparam logic [PosW-1:0] OneQ16 = 17'h10000;

    typedef enum logic [1:0] {
        CMD_EVAL = 2'd0,
        CMD_INSERT = 2'd1,
        CMD_REMOVE = 2'd2,
        CMD_SET = 2'd3
    } cmd_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SRCH_RD,
        ST_SRCH_CMP,
        ST_DIV,
        ST_LERP,
        ST_SHIFT_RD,
        ST_SHIFT_WR,
        ST_SET_RD,
        ST_PUT,
        ST_DONE
    } state_t;
endpackage
`default_nettype wire

### src/piecewise_linear_stop_table.sv
// Top level of the piecewise linear stop table: sequencer, stop memory and shared
// divide / multiply unit. Depends on plst_pkg.
//
// channel | direction | ports
// s_      | in        | s_valid s_ready s_command s_position s_stop_index s_new_*
// m_      | out       | m_valid m_ready m_status m_result_index m_result_position m_*
//
// An evaluate reads stops up to the bracketing segment, runs the restoring divide,
// does the lerps on the shared multiplier and posts the result; an insert then shifts
// the stops above its place up and writes the new stop; a remove shifts the stops
// above the index down; a set rewrites one entry's levels; a refusal posts its status.
// Reset sets the count to two and clears the per-entry written flags; an unwritten
// entry reads as zero with entry 1 at position 1.0, which gives the two endpoints.
// The block takes no transaction while one is in progress or its result waits on m_ready.
`default_nettype none
module piecewise_linear_stop_table (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [1:0]  s_command,
    input  wire logic [16:0] s_position,
    input  wire logic [4:0]  s_stop_index,
    input  wire logic signed [15:0] s_new_left_intensity,
    input  wire logic signed [15:0] s_new_right_intensity,
    input  wire logic signed [15:0] s_new_left_opacity,
    input  wire logic signed [15:0] s_new_right_opacity,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic             m_status,
    output logic [4:0]       m_result_index,
    output logic [16:0]      m_result_position,
    output logic signed [15:0] m_left_intensity,
    output logic signed [15:0] m_right_intensity,
    output logic signed [15:0] m_left_opacity,
    output logic signed [15:0] m_right_opacity
);
    localparam int IW = plst_pkg::IdxW;
    localparam int CW = plst_pkg::CntW;
    localparam int PW = plst_pkg::PosW;
    localparam int LW = plst_pkg::LvlW;
    localparam int MW = PW + 4 * LW;

    // Stop memory: position and four levels per entry, one read and one write port.
    logic [MW-1:0] mem [plst_pkg::MaxStops];
    logic [plst_pkg::MaxStops-1:0] vld_reg, vld_next;
    logic [IW-1:0] raddr;
    logic [IW-1:0] raddr_q;
    logic [MW-1:0] rdata_reg;
    logic          rvld_reg;
    logic          we;
    logic [IW-1:0] waddr;
    logic [MW-1:0] wdata;
    logic [MW-1:0] rd_view;
    logic [PW-1:0] cur_pos;

    plst_pkg::state_t st_reg, st_next;
    logic [1:0]    cmd_reg;
    logic [PW-1:0] t_reg;
    logic [IW-1:0] sidx_reg;
    logic [4*LW-1:0] newl_reg;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic [CW-1:0] i_reg;                // scan / shift pointer
    logic [MW-1:0] ea_reg;               // stop a of the segment
    logic [MW-1:0] eb_reg;               // stop b
    logic          have_a_reg;
    logic [CW-1:0] at_reg;               // insert place
    logic [PW-1:0] rem_reg;              // divider remainder
    logic [PW-1:0] q_reg;                // divider quotient = localT
    logic [4:0]    dcnt_reg;
    logic [2:0]    lk_reg;               // lerp lane
    logic [PW-1:0] rpos_reg;
    logic [4*LW-1:0] rlv_reg;
    logic          status_reg;
    logic [IW-1:0] ridx_reg;
    logic          outv_reg;

    logic signed [PW+1:0] xa, xb, xd;
    logic signed [PW+PW+2:0] prod;
    logic signed [PW+1:0] lres;
    logic [PW-1:0] span;
    logic [PW:0]   trial;
    logic [PW-1:0] num;
    logic          accept;
    logic          bracket;
    logic          last_seg;

    // Entry view: unwritten entries read as the reset endpoints.
    always_comb begin
        rd_view = rdata_reg;
        if (!rvld_reg) begin
            rd_view = '0;
            if (raddr_q == IW'(1)) rd_view[MW-1 -: PW] = plst_pkg::OneQ16;
        end
    end

    always_ff @(posedge aclk) begin
        rdata_reg <= mem[raddr];
        if (we) mem[waddr] <= wdata;
    end
    always_ff @(posedge aclk) begin
        rvld_reg <= vld_reg[raddr];
        raddr_q  <= raddr;
    end

    // Shared lerp operand select: lane 0 position, lanes 1..4 levels.
    always_comb begin
        unique case (lk_reg)
            3'd0: begin
                xa = $signed({2'b00, ea_reg[MW-1 -: PW]});
                xb = $signed({2'b00, eb_reg[MW-1 -: PW]});
            end
            3'd1: begin
                xa = (PW+2)'($signed(ea_reg[4*LW-1 -: LW]));
                xb = (PW+2)'($signed(eb_reg[4*LW-1 -: LW]));
            end
            3'd2: begin
                xa = (PW+2)'($signed(ea_reg[3*LW-1 -: LW]));
                xb = (PW+2)'($signed(eb_reg[3*LW-1 -: LW]));
            end
            3'd3: begin
                xa = (PW+2)'($signed(ea_reg[2*LW-1 -: LW]));
                xb = (PW+2)'($signed(eb_reg[2*LW-1 -: LW]));
            end
            default: begin
                xa = (PW+2)'($signed(ea_reg[LW-1:0]));
                xb = (PW+2)'($signed(eb_reg[LW-1:0]));
            end
        endcase
        xd = xb - xa;
        prod = (PW+PW+3)'(xd) * $signed({2'b00, q_reg});
    end
    assign lres = xa + (PW+2)'(prod >>> 16);

    // Divider step: restoring, one quotient bit per cycle. The numerator never
    // exceeds the span, so the first step yields the integer bit and each later
    // step doubles the remainder for one fraction bit.
    assign span  = eb_reg[MW-1 -: PW] - ea_reg[MW-1 -: PW];
    assign num   = t_reg - ea_reg[MW-1 -: PW];
    assign trial = (dcnt_reg == 5'd0) ? {1'b0, rem_reg} : {rem_reg, 1'b0};

    assign cur_pos  = rd_view[MW-1 -: PW];
    assign bracket  = t_reg >= ea_reg[MW-1 -: PW] && t_reg <= cur_pos;
    assign last_seg = i_reg + CW'(1) >= cnt_reg;

    assign accept = s_valid && s_ready;
    assign s_ready = (st_reg == plst_pkg::ST_IDLE) && !outv_reg;

    // Next state.
    always_comb begin
        st_next = st_reg;
        unique case (st_reg)
            plst_pkg::ST_IDLE: if (accept) begin
                if (s_command == plst_pkg::CMD_EVAL) st_next = plst_pkg::ST_SRCH_RD;
                else if (s_command == plst_pkg::CMD_INSERT)
                    st_next = (cnt_reg >= CW'(plst_pkg::MaxStops)) ? plst_pkg::ST_DONE
                                                                    : plst_pkg::ST_SRCH_RD;
                else if (s_command == plst_pkg::CMD_REMOVE)
                    st_next = (s_stop_index == '0 ||
                               CW'(s_stop_index) + CW'(1) >= cnt_reg) ? plst_pkg::ST_DONE
                                                                      : plst_pkg::ST_SHIFT_RD;
                else
                    st_next = (CW'(s_stop_index) >= cnt_reg) ? plst_pkg::ST_DONE
                                                             : plst_pkg::ST_SET_RD;
            end
            plst_pkg::ST_SRCH_RD: st_next = plst_pkg::ST_SRCH_CMP;
            plst_pkg::ST_SRCH_CMP: begin
                if (!have_a_reg) st_next = plst_pkg::ST_SRCH_RD;
                else if (bracket) st_next = plst_pkg::ST_DIV;
                else if (last_seg) st_next = plst_pkg::ST_LERP;
                else st_next = plst_pkg::ST_SRCH_RD;
            end
            plst_pkg::ST_DIV: if (dcnt_reg == 5'd16) st_next = plst_pkg::ST_LERP;
            plst_pkg::ST_LERP: if (lk_reg == 3'd4) begin
                if (cmd_reg == plst_pkg::CMD_INSERT)
                    st_next = (at_reg == cnt_reg) ? plst_pkg::ST_PUT : plst_pkg::ST_SHIFT_RD;
                else st_next = plst_pkg::ST_DONE;
            end
            plst_pkg::ST_SHIFT_RD: st_next = plst_pkg::ST_SHIFT_WR;
            plst_pkg::ST_SHIFT_WR: begin
                if (cmd_reg == plst_pkg::CMD_REMOVE)
                    st_next = (i_reg + CW'(2) >= cnt_reg) ? plst_pkg::ST_DONE
                                                          : plst_pkg::ST_SHIFT_RD;
                else
                    st_next = (i_reg - CW'(1) <= at_reg) ? plst_pkg::ST_PUT
                                                         : plst_pkg::ST_SHIFT_RD;
            end
            plst_pkg::ST_SET_RD: st_next = plst_pkg::ST_PUT;
            plst_pkg::ST_PUT: st_next = plst_pkg::ST_DONE;
            plst_pkg::ST_DONE: st_next = plst_pkg::ST_IDLE;
            default: st_next = plst_pkg::ST_IDLE;
        endcase
    end

    // Memory port control.
    always_comb begin
        raddr = IW'(i_reg);
        we    = 1'b0;
        waddr = IW'(i_reg);
        wdata = rd_view;
        vld_next = vld_reg;
        unique case (st_reg)
            plst_pkg::ST_SHIFT_RD: raddr = (cmd_reg == plst_pkg::CMD_REMOVE)
                                           ? IW'(i_reg + CW'(1)) : IW'(i_reg - CW'(1));
            plst_pkg::ST_SHIFT_WR: begin
                we = 1'b1;
                waddr = IW'(i_reg);
                wdata = rd_view;
            end
            plst_pkg::ST_PUT: begin
                we = 1'b1;
                if (cmd_reg == plst_pkg::CMD_SET) begin
                    // keep the position read in the cycle before
                    waddr = sidx_reg;
                    wdata = {cur_pos, newl_reg};
                end else begin
                    waddr = IW'(at_reg);
                    wdata = {rpos_reg, rlv_reg};
                end
            end
            default: ;
        endcase
        if (we) vld_next[waddr] = 1'b1;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg   <= plst_pkg::ST_IDLE;
            vld_reg  <= '0;
            cnt_reg  <= CW'(2);
            outv_reg <= 1'b0;
        end else begin
            st_reg  <= st_next;
            vld_reg <= vld_next;
            cnt_reg <= cnt_next;
            if (st_reg == plst_pkg::ST_DONE) outv_reg <= 1'b1;
            else if (m_valid && m_ready) outv_reg <= 1'b0;
        end
    end

    always_comb begin
        cnt_next = cnt_reg;
        if (st_reg == plst_pkg::ST_PUT && cmd_reg == plst_pkg::CMD_INSERT)
            cnt_next = cnt_reg + CW'(1);
        if (st_reg == plst_pkg::ST_SHIFT_WR && cmd_reg == plst_pkg::CMD_REMOVE &&
            i_reg + CW'(2) >= cnt_reg)
            cnt_next = cnt_reg - CW'(1);
    end

    // Datapath registers.
    always_ff @(posedge aclk) begin
        unique case (st_reg)
            plst_pkg::ST_IDLE: if (accept) begin
                cmd_reg    <= s_command;
                sidx_reg   <= s_stop_index;
                newl_reg   <= {s_new_left_intensity, s_new_right_intensity,
                               s_new_left_opacity, s_new_right_opacity};
                i_reg      <= '0;
                have_a_reg <= 1'b0;
                rpos_reg   <= '0;
                rlv_reg    <= '0;
                ridx_reg   <= '0;
                status_reg <= 1'b0;
                if (s_command == plst_pkg::CMD_INSERT) begin
                    t_reg <= (s_position == '0) ? PW'(1)
                           : (s_position > plst_pkg::OneQ16 - PW'(1))
                             ? plst_pkg::OneQ16 - PW'(1) : s_position;
                    status_reg <= cnt_reg >= CW'(plst_pkg::MaxStops);
                end else begin
                    t_reg <= (s_position > plst_pkg::OneQ16) ? plst_pkg::OneQ16 : s_position;
                end
                if (s_command == plst_pkg::CMD_REMOVE) begin
                    i_reg <= CW'(s_stop_index);
                    status_reg <= (s_stop_index == '0 ||
                                   CW'(s_stop_index) + CW'(1) >= cnt_reg);
                end
                if (s_command == plst_pkg::CMD_SET) begin
                    i_reg <= CW'(s_stop_index);
                    status_reg <= CW'(s_stop_index) >= cnt_reg;
                end
            end
            plst_pkg::ST_SRCH_CMP: begin
                if (!have_a_reg) begin
                    ea_reg <= rd_view; have_a_reg <= 1'b1; i_reg <= i_reg + CW'(1);
                end else if (bracket) begin
                    // The table stays sorted with stop 0 at zero, so every stop up to a lies at or below
                    // t and b is the first stop after a that lies at or after t.
                    eb_reg <= rd_view;
                    at_reg <= i_reg;
                    rem_reg <= num; q_reg <= '0; dcnt_reg <= '0;
                end else if (last_seg) begin
                    // no bracket: return the last stop as is
                    ea_reg <= rd_view; eb_reg <= rd_view;
                    at_reg <= cnt_reg;
                    q_reg <= '0;
                end else begin
                    ea_reg <= rd_view; i_reg <= i_reg + CW'(1);
                end
                lk_reg <= '0;
            end
            plst_pkg::ST_DIV: begin
                dcnt_reg <= dcnt_reg + 5'd1;
                if (span == '0) q_reg <= '0;
                else if (trial >= {1'b0, span}) begin
                    rem_reg <= PW'(trial - {1'b0, span});
                    q_reg <= {q_reg[PW-2:0], 1'b1};
                end else begin
                    rem_reg <= PW'(trial);
                    q_reg <= {q_reg[PW-2:0], 1'b0};
                end
                lk_reg <= '0;
            end
            plst_pkg::ST_LERP: begin
                lk_reg <= lk_reg + 3'd1;
                unique case (lk_reg)
                    3'd0: rpos_reg <= PW'(lres);
                    3'd1: rlv_reg[4*LW-1 -: LW] <= LW'(lres);
                    3'd2: rlv_reg[3*LW-1 -: LW] <= LW'(lres);
                    3'd3: rlv_reg[2*LW-1 -: LW] <= LW'(lres);
                    default: rlv_reg[LW-1:0] <= LW'(lres);
                endcase
                // start the upward shift from the top of the table
                if (lk_reg == 3'd4 && cmd_reg == plst_pkg::CMD_INSERT) i_reg <= cnt_reg;
            end
            plst_pkg::ST_SHIFT_WR: begin
                if (cmd_reg == plst_pkg::CMD_REMOVE) i_reg <= i_reg + CW'(1);
                else i_reg <= i_reg - CW'(1);
            end
            plst_pkg::ST_PUT: if (cmd_reg == plst_pkg::CMD_INSERT) ridx_reg <= IW'(at_reg);
            default: ;
        endcase
    end

    assign m_valid = outv_reg;
    assign m_status = status_reg;
    assign m_result_index = ridx_reg;
    assign m_result_position = rpos_reg;
    assign m_left_intensity  = rlv_reg[4*LW-1 -: LW];
    assign m_right_intensity = rlv_reg[3*LW-1 -: LW];
    assign m_left_opacity    = rlv_reg[2*LW-1 -: LW];
    assign m_right_opacity   = rlv_reg[LW-1:0];

    assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg >= CW'(2) && cnt_reg <= CW'(plst_pkg::MaxStops))
        else $error("stop count out of range");
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_ready |-> !m_valid)
        else $error("ready while result pending");
    assert property (@(posedge aclk) disable iff (!aresetn)
        (st_reg == plst_pkg::ST_DONE) |=> m_valid)
        else $error("result not presented");
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid &&
            $stable({m_status, m_result_index, m_result_position, rlv_reg}))
        else $error("result changed while stalled");
endmodule
`default_nettype wire

### verif/piecewise_linear_stop_table_tb.sv
// Testbench for the piecewise linear stop table: directed and random commands
// checked against an in-bench model of the sorted stop table. Depends on plst_pkg.
`timescale 1ns / 100ps
`default_nettype none
module piecewise_linear_stop_table_tb;
    localparam int CycleLimit = 2_000_000;

    typedef struct packed {
        logic        status;
        logic [4:0]  index;
        logic [16:0] position;
        logic [15:0] li;
        logic [15:0] ri;
        logic [15:0] lo;
        logic [15:0] ro;
    } outcome_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    logic [1:0] s_command = plst_pkg::CMD_EVAL;
    logic [16:0] s_position = '0;
    logic [4:0] s_stop_index = '0;
    logic signed [15:0] s_new_left_intensity = '0;
    logic signed [15:0] s_new_right_intensity = '0;
    logic signed [15:0] s_new_left_opacity = '0;
    logic signed [15:0] s_new_right_opacity = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    logic m_status;
    logic [4:0] m_result_index;
    logic [16:0] m_result_position;
    logic signed [15:0] m_left_intensity;
    logic signed [15:0] m_right_intensity;
    logic signed [15:0] m_left_opacity;
    logic signed [15:0] m_right_opacity;

    piecewise_linear_stop_table uut (.*);

    // Mirror of the block's table.
    logic [16:0] mirror_pos [plst_pkg::MaxStops];
    logic signed [15:0] mirror_lvl [plst_pkg::MaxStops][4];
    int mirror_count;

    outcome_t pending_outcomes[$];
    int errors = 0;
    longint cycles = 0;
    bit calm = 1'b0;   // when set, neither side idles

    initial begin
        forever #1 aclk = ~aclk;
    end

    // Stop the run if it hangs.
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CycleLimit) begin
            $display("piecewise_linear_stop_table test failed");
            $finish;
        end
    end

    // Floor of (xb - xa) * lt / 65536 added to xa.
    function automatic longint lerp_floor(longint xa, longint xb, longint lt);
        longint prod;
        prod = (xb - xa) * lt;
        return xa + (prod >>> 16);
    endfunction

    function automatic outcome_t table_lookup(logic [16:0] t);
        outcome_t r;
        longint span, lt;
        int i, k;
        logic signed [15:0] lv [4];
        r = '0;
        for (i = 0; i + 1 < mirror_count; i++) begin
            if (t >= mirror_pos[i] && t <= mirror_pos[i+1]) begin
                span = mirror_pos[i+1] - mirror_pos[i];
                lt = (span > 0) ? ((longint'(t - mirror_pos[i]) << 16) / span) : 0;
                r.position = 17'(lerp_floor(mirror_pos[i], mirror_pos[i+1], lt));
                for (k = 0; k < 4; k++)
                    lv[k] = 16'(lerp_floor(mirror_lvl[i][k], mirror_lvl[i+1][k], lt));
                r.li = lv[0]; r.ri = lv[1]; r.lo = lv[2]; r.ro = lv[3];
                return r;
            end
        end
        // Unreachable while sorted: return the last stop.
        i = mirror_count - 1;
        r.position = mirror_pos[i];
        r.li = mirror_lvl[i][0]; r.ri = mirror_lvl[i][1];
        r.lo = mirror_lvl[i][2]; r.ro = mirror_lvl[i][3];
        return r;
    endfunction

    // Apply one command to the mirror and return its outcome.
    function automatic outcome_t apply_command(logic [1:0] cmd, logic [16:0] p,
                                               logic [4:0] idx,
                                               logic signed [15:0] nl [4]);
        outcome_t r;
        int j, at;
        r = '0;
        case (cmd)
            plst_pkg::CMD_EVAL: begin
                if (p > plst_pkg::OneQ16) p = plst_pkg::OneQ16;
                r = table_lookup(p);
            end
            plst_pkg::CMD_INSERT: begin
                if (mirror_count >= plst_pkg::MaxStops) begin
                    r.status = 1'b1;
                end else begin
                    if (p < 1) p = 1;
                    if (p > plst_pkg::OneQ16 - 1) p = plst_pkg::OneQ16 - 1;
                    r = table_lookup(p);
                    at = mirror_count;
                    for (j = 0; j < mirror_count; j++)
                        if (mirror_pos[j] >= p) begin
                            at = j;
                            break;
                        end
                    for (j = mirror_count; j > at; j--) begin
                        mirror_pos[j] = mirror_pos[j-1];
                        mirror_lvl[j] = mirror_lvl[j-1];
                    end
                    mirror_pos[at] = r.position;
                    mirror_lvl[at][0] = r.li; mirror_lvl[at][1] = r.ri;
                    mirror_lvl[at][2] = r.lo; mirror_lvl[at][3] = r.ro;
                    mirror_count++;
                    r.index = 5'(at);
                end
            end
            plst_pkg::CMD_REMOVE: begin
                if (idx == 0 || idx + 1 >= mirror_count) begin
                    r.status = 1'b1;
                end else begin
                    for (j = idx; j + 1 < mirror_count; j++) begin
                        mirror_pos[j] = mirror_pos[j+1];
                        mirror_lvl[j] = mirror_lvl[j+1];
                    end
                    mirror_count--;
                end
            end
            default: begin
                if (idx >= mirror_count) r.status = 1'b1;
                else mirror_lvl[idx] = nl;
            end
        endcase
        return r;
    endfunction

    // Send one transaction; hold valid and payload until it is accepted.
    // Called at a falling edge; returns at the falling edge after acceptance.
    task automatic send_command(logic [1:0] cmd, logic [16:0] p, logic [4:0] idx,
                                logic signed [15:0] nl [4]);
        while (!calm && $urandom_range(99) < 24) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_command <= cmd;
        s_position <= p;
        s_stop_index <= idx;
        s_new_left_intensity <= nl[0];
        s_new_right_intensity <= nl[1];
        s_new_left_opacity <= nl[2];
        s_new_right_opacity <= nl[3];
        do @(posedge aclk); while (!s_ready);
        pending_outcomes.push_back(apply_command(cmd, p, idx, nl));
        @(negedge aclk);
    endtask

    function automatic logic [16:0] any_position();
        case ($urandom_range(7))
            0: return 17'($urandom_range(3));
            1: return 17'($urandom_range(65536, 65532));
            2: return 17'($urandom_range(131071, 65537));
            default: return 17'($urandom_range(65536));
        endcase
    endfunction

    task automatic send_random(logic [1:0] cmd);
        logic signed [15:0] nl [4];
        foreach (nl[k]) nl[k] = 16'($urandom);
        send_command(cmd, any_position(), 5'($urandom), nl);
    endtask

    // Drop valid and hold until every expected result has arrived.
    task automatic drain();
        s_valid <= 1'b0;
        do @(negedge aclk); while (pending_outcomes.size() != 0);
    endtask

    // Extremes, every command and each corner named for the table.
    task automatic test_directed();
        logic signed [15:0] top [4];
        logic signed [15:0] bot [4];
        top = '{16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff};
        bot = '{-16'sh8000, -16'sh8000, -16'sh8000, -16'sh8000};
        send_command(plst_pkg::CMD_EVAL, 17'd0, 5'd0, top);
        send_command(plst_pkg::CMD_EVAL, 17'h1ffff, 5'd31, top);     // query above 1.0
        send_command(plst_pkg::CMD_SET, 17'd0, 5'd0, top);
        send_command(plst_pkg::CMD_SET, 17'd0, 5'd1, bot);
        send_command(plst_pkg::CMD_SET, 17'd0, 5'd2, top);           // index past count
        send_command(plst_pkg::CMD_EVAL, 17'd32768, 5'd0, top);
        send_command(plst_pkg::CMD_INSERT, 17'd0, 5'd0, top);        // clamp at low end
        send_command(plst_pkg::CMD_INSERT, 17'h1ffff, 5'd0, top);    // clamp at high end
        send_command(plst_pkg::CMD_INSERT, 17'd32768, 5'd0, top);
        send_command(plst_pkg::CMD_INSERT, 17'd32768, 5'd0, top);    // equal position
        send_command(plst_pkg::CMD_EVAL, 17'd32768, 5'd0, top);
        send_command(plst_pkg::CMD_EVAL, 17'd1, 5'd0, top);
        send_command(plst_pkg::CMD_REMOVE, 17'd0, 5'd0, top);        // first endpoint
        send_command(plst_pkg::CMD_REMOVE, 17'd0, 5'd5, top);        // last endpoint
        send_command(plst_pkg::CMD_REMOVE, 17'd0, 5'd31, top);       // past count
        send_command(plst_pkg::CMD_REMOVE, 17'd0, 5'd2, top);
        send_command(plst_pkg::CMD_SET, 17'd0, 5'd3, bot);
        send_command(plst_pkg::CMD_EVAL, 17'd65535, 5'd0, top);
        drain();
    endtask

    // Fill the table to refusal, then empty it again with the sender calm.
    task automatic test_full_table();
        calm = 1'b1;
        while (mirror_count < plst_pkg::MaxStops) send_random(plst_pkg::CMD_INSERT);
        repeat (4) send_random(plst_pkg::CMD_INSERT);                // refused: table full
        repeat (4) send_random(plst_pkg::CMD_EVAL);
        while (mirror_count > 2) begin
            logic signed [15:0] nl [4];
            nl = '{0, 0, 0, 0};
            send_command(plst_pkg::CMD_REMOVE, 17'd0,
                         5'($urandom_range(mirror_count - 2, 1)), nl);
        end
        calm = 1'b0;
        drain();
    endtask

    // Mostly evaluate and set, with inserts and removes keeping the table mid-sized.
    task automatic test_random_mix(int n);
        int i;
        for (i = 0; i < n; i++) begin
            if (i == n / 2) drain();                           // pause until idle
            case ($urandom_range(9))
                0, 1, 2, 3: send_random(plst_pkg::CMD_EVAL);
                4, 5: send_random(plst_pkg::CMD_SET);
                6, 7: send_random(mirror_count < 24 ? plst_pkg::CMD_INSERT
                                                    : plst_pkg::CMD_REMOVE);
                default: send_random(mirror_count > 6 ? plst_pkg::CMD_REMOVE
                                                      : plst_pkg::CMD_INSERT);
            endcase
        end
        drain();
    endtask

    // Receiver: random back-pressure, with a calm stretch.
    always @(negedge aclk)
        m_ready <= calm ? 1'b1 : ($urandom_range(99) >= 24);

    // Check each result transaction against the oldest expectation.
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            outcome_t want, got;
            got = '{m_status, m_result_index, m_result_position, m_left_intensity,
                    m_right_intensity, m_left_opacity, m_right_opacity};
            if (pending_outcomes.size() == 0) begin
                $display("%0t: unexpected result %h", $time, got);
                errors++;
            end else begin
                want = pending_outcomes.pop_front();
                if (got !== want) begin
                    $display("%0t: mismatch expected %h actual %h", $time, want, got);
                    errors++;
                end
            end
        end
    end

    initial begin
        mirror_count = 2;
        foreach (mirror_pos[i]) mirror_pos[i] = '0;
        foreach (mirror_lvl[i, k]) mirror_lvl[i][k] = '0;
        mirror_pos[1] = plst_pkg::OneQ16;
        repeat (12) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        test_directed();
        test_full_table();
        test_random_mix(600);
        calm = 1'b1;
        test_random_mix(150);
        calm = 1'b0;
        test_random_mix(500);
        repeat (200) @(posedge aclk);
        if (errors == 0 && pending_outcomes.size() == 0)
            $display("piecewise_linear_stop_table test passed");
        else
            $display("piecewise_linear_stop_table test failed");
        $finish;
    end
endmodule
`default_nettype wire

### filelist.f
src/plst_pkg.sv
src/piecewise_linear_stop_table.sv
verif/piecewise_linear_stop_table_tb.sv
